@@ sv/adc_trimmed_mean_filter_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the ADC trimmed-mean filter
// Short forms for clocked, reset-gated concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ADC_TRIMMED_MEAN_FILTER_ASSERT_SVH
`define ADC_TRIMMED_MEAN_FILTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ATMF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ATMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/atmf_pkg.sv @@
// ----------------------------------------------------------------------------
// atmf_pkg
// Fixed widths and scaling constants of the ADC trimmed-mean filter.
// ----------------------------------------------------------------------------
package atmf_pkg;

  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned FULL_SCALE  = 4095;

  // avg*255/4095 == avg*17/273; 1/273 by reciprocal, exact for avg*17 < 2^17
  localparam int unsigned SCALE_SHIFT  = 26;
  localparam int unsigned SCALE_MULT_W = 23;
  localparam logic [SCALE_MULT_W-1:0] SCALE_MULT =
      SCALE_MULT_W'(17 * (((1 << SCALE_SHIFT) + 272) / 273));
  localparam int unsigned SCALE_PROD_W = SAMPLE_W + SCALE_MULT_W;

endpackage

@@ sv/adc_trimmed_mean_filter.sv @@
// ----------------------------------------------------------------------------
// adc_trimmed_mean_filter
// Windowed mean of converter samples with the smallest and largest dropped.
// ----------------------------------------------------------------------------
// Takes one sample per cycle. Each window of WINDOW_SAMPLES samples is summed
// while its smallest and largest values are tracked; on the closing sample the
// extremes are removed and the rest divided by WINDOW_SAMPLES-2 (truncated),
// optionally rescaled to 0..255 by the mode bit of the closing sample. On its
// way to the output the result passes three registers: one for the trimmed
// sum, one after the reciprocal multiply that divides it, and the output
// register after the scaling multiply. The input only stalls while all three
// stages hold results and the one at the output is not taken.

`include "adc_trimmed_mean_filter_assert.svh"

module adc_trimmed_mean_filter #(
  parameter int unsigned WINDOW_SAMPLES = 22
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [atmf_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          eight_bit_mode_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [atmf_pkg::SAMPLE_W-1:0] value_o,
  output logic                          is_eight_bit_o
);

  localparam int unsigned SW       = atmf_pkg::SAMPLE_W;
  localparam int unsigned CntW     = $clog2(WINDOW_SAMPLES);
  localparam int unsigned SumW     = $clog2(WINDOW_SAMPLES * atmf_pkg::FULL_SCALE + 1);
  localparam int unsigned Div      = WINDOW_SAMPLES - 2;
  // error term of the reciprocal is below 32, so 5 extra bits keep it exact
  localparam int unsigned DivShift = SumW + 5;
  localparam int unsigned DivMultW = DivShift + 1;
  localparam int unsigned DivProdW = SumW + DivMultW;
  localparam logic [DivMultW-1:0] DivMult =
      DivMultW'(((64'd1 << DivShift) + 64'(Div) - 64'd1) / 64'(Div));
  localparam logic [CntW-1:0] LastIdx = CntW'(WINDOW_SAMPLES - 1);
  localparam logic [SumW-1:0] TrimMax = SumW'(Div * atmf_pkg::FULL_SCALE);
  localparam logic [SumW-1:0] AvgMax  = SumW'(atmf_pkg::FULL_SCALE);

  // window accumulator
  logic [CntW-1:0] cnt_q,  cnt_d;
  logic [SumW-1:0] sum_q,  sum_d;
  logic [SW-1:0]   max_q,  max_d;
  logic [SW-1:0]   min_q,  min_d;

  // pipeline stages
  logic            tv_q;
  logic [SumW-1:0] trim_q;
  logic            tmode_q;
  logic            av_q;
  logic [SW-1:0]   avg_q;
  logic            amode_q;
  logic            ov_q;
  logic [SW-1:0]   value_q;
  logic            eb_q;

  logic in_xfer, first_smp, last_smp;
  logic out_load, av_free, av_load, t_free;
  logic [SumW-1:0]     trim_d;
  logic [DivProdW-1:0] div_prod;
  logic [SumW-1:0]     quot;
  logic [atmf_pkg::SCALE_PROD_W-1:0] scale_prod;
  logic [SW-1:0]       value_d;

  assign out_load   = av_q && (!ov_q || out_ready_i);
  assign av_free    = !av_q || out_load;
  assign av_load    = tv_q && av_free;
  assign t_free     = !tv_q || av_free;
  assign in_ready_o = t_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign first_smp = (cnt_q == '0);
  assign last_smp  = (cnt_q == LastIdx);

  always_comb begin
    if (first_smp) begin
      sum_d = SumW'(sample_i);
      max_d = sample_i;
      min_d = sample_i;
    end else begin
      sum_d = sum_q + SumW'(sample_i);
      max_d = (sample_i > max_q) ? sample_i : max_q;
      min_d = (sample_i < min_q) ? sample_i : min_q;
    end
    cnt_d  = last_smp ? '0 : cnt_q + 1'b1;
    trim_d = sum_d - SumW'(max_d) - SumW'(min_d);
  end

  // divide by WINDOW_SAMPLES-2 via reciprocal multiply
  assign div_prod = DivProdW'(trim_q) * DivProdW'(DivMult);
  assign quot     = SumW'(div_prod >> DivShift);

  // 8-bit rescale
  assign scale_prod = atmf_pkg::SCALE_PROD_W'(avg_q) *
                      atmf_pkg::SCALE_PROD_W'(atmf_pkg::SCALE_MULT);
  assign value_d    = amode_q ? SW'(scale_prod >> atmf_pkg::SCALE_SHIFT) : avg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sum_q <= '0;
      max_q <= '0;
      min_q <= '0;
      tv_q  <= 1'b0;
      av_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      if (in_xfer) begin
        cnt_q <= cnt_d;
        sum_q <= last_smp ? '0 : sum_d;
        max_q <= last_smp ? '0 : max_d;
        min_q <= last_smp ? '0 : min_d;
      end
      if (in_xfer && last_smp) begin
        tv_q <= 1'b1;
      end else if (av_load) begin
        tv_q <= 1'b0;
      end
      if (av_load) begin
        av_q <= 1'b1;
      end else if (out_load) begin
        av_q <= 1'b0;
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && last_smp) begin
      trim_q  <= trim_d;
      tmode_q <= eight_bit_mode_i;
    end
    if (av_load) begin
      avg_q   <= SW'(quot);
      amode_q <= tmode_q;
    end
    if (out_load) begin
      value_q <= value_d;
      eb_q    <= amode_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign value_o        = value_q;
  assign is_eight_bit_o = eb_q;

  `ATMF_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= LastIdx, "sample count past window end")
  `ATMF_ASSERT_IMPL(a_min_le_max, !first_smp, min_q <= max_q, "window minimum above maximum")
  `ATMF_ASSERT_IMPL(a_trim_range, tv_q, trim_q <= TrimMax, "trimmed sum underflow")
  `ATMF_ASSERT_IMPL(a_quot_fits, tv_q, quot <= AvgMax, "average exceeds sample range")
  `ATMF_ASSERT_NEXT(a_close_loads, in_xfer && last_smp, tv_q, "closing sample not captured")

endmodule
